// ===== hdl/ptlp_pkg.sv =====
// ----------------------------------------------------------------------------
// ptlp_pkg
// Types, widths and constants of the pan/tilt leaky PID head controller.
// ----------------------------------------------------------------------------
package ptlp_pkg;

   // field widths
   localparam int unsigned ActW     = 3;
   localparam int unsigned TickW    = 12;
   localparam int unsigned AngleW   = 16;
   localparam int unsigned GainW    = 16;
   localparam int unsigned IntegW   = 24;
   localparam int unsigned DtW      = 20;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   // shared multiplier: signed operand times unsigned gain or constant
   localparam int unsigned MulAW = 25;
   localparam int unsigned MulBW = 16;
   localparam int unsigned ProdW = MulAW + MulBW + 1;

   // derivative divider and accumulator
   localparam int unsigned QuotW    = 36;
   localparam int unsigned DerivW   = QuotW + 1;
   localparam int unsigned DerivLoW = 19;
   localparam int unsigned DivCntW  = $clog2(QuotW);
   localparam int unsigned AccW     = 54;
   localparam int unsigned SatW     = 48;

   // fixed-point constants
   localparam int unsigned RadPerTickQ20 = 5360;
   localparam int unsigned LeakQ15       = 29491;
   localparam int unsigned UsScaleOdd    = 15625;   // 1e6 = 15625 * 64
   localparam int unsigned UsScaleShift  = 6;
   localparam int unsigned TickShift     = 8;
   localparam int unsigned LeakShift     = 15;
   localparam int unsigned OutShift      = 12;

   // reset values of the control registers
   localparam logic [GainW-1:0] PanKpReset  = GainW'(410);
   localparam logic [GainW-1:0] PanKiReset  = GainW'(41);
   localparam logic [GainW-1:0] PanKdReset  = GainW'(328);
   localparam logic [GainW-1:0] TiltKpReset = GainW'(1229);
   localparam logic [GainW-1:0] TiltKiReset = GainW'(20);
   localparam logic [GainW-1:0] TiltKdReset = GainW'(287);
   localparam logic [TickW-1:0] ZeroReset   = TickW'(512);

   typedef enum logic [ActW-1:0] {
      ACT_TILT_REPORT = 3'd0,
      ACT_PAN_REPORT  = 3'd1,
      ACT_ABS_MOVE    = 3'd2,
      ACT_REL_MOVE    = 3'd3,
      ACT_TRACKER     = 3'd4
   } action_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_PAN_KP    = 3'd0,
      CSR_PAN_KI    = 3'd1,
      CSR_PAN_KD    = 3'd2,
      CSR_TILT_KP   = 3'd3,
      CSR_TILT_KI   = 3'd4,
      CSR_TILT_KD   = 3'd5,
      CSR_PAN_ZERO  = 3'd6,
      CSR_TILT_ZERO = 3'd7
   } csr_index_type;

   // clamp to a signed 16-bit angle
   function automatic logic signed [AngleW-1:0] sat_angle(input logic signed [SatW-1:0] v);
      logic signed [SatW-1:0] hi;
      logic signed [SatW-1:0] lo;
      hi = SatW'(32767);
      lo = -SatW'(32768);
      if (v > hi) begin
         sat_angle = AngleW'(hi);
      end else if (v < lo) begin
         sat_angle = AngleW'(lo);
      end else begin
         sat_angle = AngleW'(v);
      end
   endfunction

   // clamp to a signed 24-bit integral
   function automatic logic signed [IntegW-1:0] sat_integ(input logic signed [SatW-1:0] v);
      logic signed [SatW-1:0] hi;
      logic signed [SatW-1:0] lo;
      hi = SatW'(8388607);
      lo = -SatW'(8388608);
      if (v > hi) begin
         sat_integ = IntegW'(hi);
      end else if (v < lo) begin
         sat_integ = IntegW'(lo);
      end else begin
         sat_integ = IntegW'(v);
      end
   endfunction

endpackage

// ===== hdl/pan_tilt_leaky_pid_core.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_leaky_pid_core
// Two-axis head controller: servo reports set the current angles, moves and tracker
// events produce absolute pan/tilt commands (through a leaky PID but for absolute moves).
// ----------------------------------------------------------------------------
// usage
//   req_*  : one beat per command (report, absolute move, relative move,
//            tracker event). req_ready is high only while the core is idle;
//            one beat is worked on at a time.
//   rsp_*  : one beat for absolute moves, relative moves and tracker events
//            with an object seen; none for reports and ignored events.
//   csr_*  : gain and zero-tick registers, written with csr_write_en.
// sequence
//   a report converts ticks to an angle and returns to idle; an absolute
//   move goes from decode to the output register; a PID move runs the
//   leaky integral, derivative divide and multiply-accumulate for tilt,
//   then for pan. The PID path is built from the 36-step restoring divider
//   for the derivative, run once per axis, and the single shared 25x16
//   multiplier used for every product.
// stalls and reset
//   a result sits in the output register; while rsp_ready is low the next
//   result waits in the core, and req_ready returns once it is handed over.
//   reset clears the angles, last errors and integrals, restores the
//   default gains and zero ticks, and drops rsp_valid.
// ----------------------------------------------------------------------------
module pan_tilt_leaky_pid_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // command beats
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ptlp_pkg::ActW-1:0]               req_action,
   input  logic [ptlp_pkg::TickW-1:0]              req_position_ticks,
   input  logic signed [ptlp_pkg::AngleW-1:0]      req_pan_value,
   input  logic signed [ptlp_pkg::AngleW-1:0]      req_tilt_value,
   input  logic                                    req_object_seen,
   input  logic [ptlp_pkg::DtW-1:0]                req_elapsed_us,
   // result beats
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ptlp_pkg::AngleW-1:0]      rsp_pan_command,
   output logic signed [ptlp_pkg::AngleW-1:0]      rsp_tilt_command,
   // register writes
   input  logic                                    csr_write_en,
   input  logic [ptlp_pkg::CsrIdxW-1:0]            csr_index,
   input  logic [ptlp_pkg::CsrDataW-1:0]           csr_wdata
);
   import ptlp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_TICK_MUL,
      S_TICK_WB,
      S_LEAK_MUL,
      S_INTEG_WB,
      S_NUM_MUL,
      S_DIV_LOAD,
      S_DIV,
      S_DERIV,
      S_KP,
      S_KI,
      S_KDL,
      S_KDH,
      S_ACC_LAST,
      S_OUT,
      S_EMIT
   } state_type;

   // control registers
   logic [GainW-1:0] pan_kp_ff, pan_ki_ff, pan_kd_ff;
   logic [GainW-1:0] tilt_kp_ff, tilt_ki_ff, tilt_kd_ff;
   logic [TickW-1:0] pan_zero_ff, tilt_zero_ff;

   // sequencer and datapath registers
   state_type                 state_ff, state_in;
   logic                      axis_ff, axis_in;          // 0 tilt, 1 pan
   action_type                act_ff, act_in;
   logic [TickW-1:0]          ticks_ff, ticks_in;
   logic signed [AngleW-1:0]  pv_ff, pv_in;
   logic signed [AngleW-1:0]  tv_ff, tv_in;
   logic                      seen_ff, seen_in;
   logic [DtW-1:0]            dt_ff, dt_in;
   logic signed [ProdW-1:0]   prod_ff, prod_in;
   logic signed [AccW-1:0]    acc_ff, acc_in;
   logic [QuotW-1:0]          numq_ff, numq_in;
   logic [DtW-1:0]            rem_ff, rem_in;
   logic [DivCntW-1:0]        cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic signed [DerivW-1:0]  deriv_ff, deriv_in;

   // controller state
   logic signed [AngleW-1:0]  cur_pan_ff, cur_pan_in;
   logic signed [AngleW-1:0]  cur_tilt_ff, cur_tilt_in;
   logic signed [AngleW-1:0]  last_pan_ff, last_pan_in;
   logic signed [AngleW-1:0]  last_tilt_ff, last_tilt_in;
   logic signed [IntegW-1:0]  integ_pan_ff, integ_pan_in;
   logic signed [IntegW-1:0]  integ_tilt_ff, integ_tilt_in;

   // command hold and output registers
   logic signed [AngleW-1:0]  pan_cmd_ff, pan_cmd_in;
   logic signed [AngleW-1:0]  tilt_cmd_ff, tilt_cmd_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [AngleW-1:0]  rsp_pan_command_ff, rsp_pan_command_in;
   logic signed [AngleW-1:0]  rsp_tilt_command_ff, rsp_tilt_command_in;

   // shared multiplier
   logic signed [MulAW-1:0]   mul_a;
   logic [MulBW-1:0]          mul_b;
   logic signed [ProdW-1:0]   mul_p;

   // per-axis selections
   logic signed [AngleW-1:0]  err_sel;
   logic signed [AngleW-1:0]  last_sel;
   logic signed [AngleW-1:0]  cur_sel;
   logic signed [IntegW-1:0]  integ_sel;
   logic [GainW-1:0]          kp_sel, ki_sel, kd_sel;
   logic signed [AngleW:0]    neg_pv;
   logic signed [AngleW-1:0]  pan_err;

   // intermediate values
   logic signed [TickW:0]     tick_diff;
   logic [TickW-1:0]          zero_sel;
   logic signed [ProdW-1:0]   tick_round;
   logic signed [ProdW-1:0]   leak_round;
   logic signed [IntegW-1:0]  integ_new;
   logic signed [AngleW:0]    err_diff;
   logic [AngleW:0]           err_mag;
   logic [DtW:0]              div_trial;
   logic                      div_bit;
   logic signed [AccW-1:0]    acc_round;
   logic signed [AngleW-1:0]  cmd_new;
   logic                      req_fire;

   assign req_ready       = (state_ff == S_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pan_command = rsp_pan_command_ff;
   assign rsp_tilt_command = rsp_tilt_command_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_kp_ff    <= PanKpReset;
         pan_ki_ff    <= PanKiReset;
         pan_kd_ff    <= PanKdReset;
         tilt_kp_ff   <= TiltKpReset;
         tilt_ki_ff   <= TiltKiReset;
         tilt_kd_ff   <= TiltKdReset;
         pan_zero_ff  <= ZeroReset;
         tilt_zero_ff <= ZeroReset;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_PAN_KP:    pan_kp_ff    <= csr_wdata;
            CSR_PAN_KI:    pan_ki_ff    <= csr_wdata;
            CSR_PAN_KD:    pan_kd_ff    <= csr_wdata;
            CSR_TILT_KP:   tilt_kp_ff   <= csr_wdata;
            CSR_TILT_KI:   tilt_ki_ff   <= csr_wdata;
            CSR_TILT_KD:   tilt_kd_ff   <= csr_wdata;
            CSR_PAN_ZERO:  pan_zero_ff  <= csr_wdata[TickW-1:0];
            CSR_TILT_ZERO: tilt_zero_ff <= csr_wdata[TickW-1:0];
            default: ;
         endcase
      end
   end

   // per-axis operand selection
   always_comb begin
      neg_pv    = -$signed({pv_ff[AngleW-1], pv_ff});
      pan_err   = (act_ff == ACT_TRACKER) ? ((neg_pv > 17'sd32767) ? 16'sd32767
                                                                   : AngleW'(neg_pv))
                                          : pv_ff;
      err_sel   = axis_ff ? pan_err      : tv_ff;
      last_sel  = axis_ff ? last_pan_ff  : last_tilt_ff;
      cur_sel   = axis_ff ? cur_pan_ff   : cur_tilt_ff;
      integ_sel = axis_ff ? integ_pan_ff : integ_tilt_ff;
      kp_sel    = axis_ff ? pan_kp_ff    : tilt_kp_ff;
      ki_sel    = axis_ff ? pan_ki_ff    : tilt_ki_ff;
      kd_sel    = axis_ff ? pan_kd_ff    : tilt_kd_ff;
      zero_sel  = (act_ff == ACT_PAN_REPORT) ? pan_zero_ff : tilt_zero_ff;
   end

   // arithmetic around the shared multiplier
   always_comb begin
      tick_diff  = $signed({1'b0, ticks_ff}) - $signed({1'b0, zero_sel});
      tick_round = (prod_ff + ProdW'(1 << (TickShift - 1))) >>> TickShift;
      leak_round = (prod_ff + ProdW'(1 << (LeakShift - 1))) >>> LeakShift;
      integ_new  = sat_integ(SatW'(leak_round) + SatW'(err_sel));
      err_diff   = $signed({err_sel[AngleW-1], err_sel})
                 - $signed({last_sel[AngleW-1], last_sel});
      err_mag    = err_diff[AngleW] ? (AngleW+1)'(-err_diff)
                                    : (AngleW+1)'(err_diff);
      div_trial  = {rem_ff, numq_ff[QuotW-1]};
      div_bit    = (div_trial >= {1'b0, dt_ff});
      acc_round  = (acc_ff + AccW'(1 << (OutShift - 1))) >>> OutShift;
      cmd_new    = sat_angle(SatW'(acc_round) + SatW'(cur_sel));
   end

   // multiplier operand steering
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_TICK_MUL: begin
            mul_a = MulAW'(tick_diff);
            mul_b = MulBW'(RadPerTickQ20);
         end
         S_LEAK_MUL: begin
            mul_a = MulAW'(integ_sel);
            mul_b = MulBW'(LeakQ15);
         end
         S_NUM_MUL: begin
            mul_a = $signed({{(MulAW-AngleW-1){1'b0}}, err_mag});
            mul_b = MulBW'(UsScaleOdd);
         end
         S_KP: begin
            mul_a = MulAW'(err_sel);
            mul_b = kp_sel;
         end
         S_KI: begin
            mul_a = MulAW'(integ_sel);
            mul_b = ki_sel;
         end
         S_KDL: begin
            mul_a = $signed({{(MulAW-DerivLoW){1'b0}}, deriv_ff[DerivLoW-1:0]});
            mul_b = kd_sel;
         end
         S_KDH: begin
            mul_a = MulAW'($signed(deriv_ff[DerivW-1:DerivLoW]));
            mul_b = kd_sel;
         end
         default: ;
      endcase
      mul_p = ProdW'(mul_a) * ProdW'($signed({1'b0, mul_b}));
   end

   // sequencer next state
   always_comb begin
      state_in            = state_ff;
      axis_in             = axis_ff;
      act_in              = act_ff;
      ticks_in            = ticks_ff;
      pv_in               = pv_ff;
      tv_in               = tv_ff;
      seen_in             = seen_ff;
      dt_in               = dt_ff;
      prod_in             = mul_p;
      acc_in              = acc_ff;
      numq_in             = numq_ff;
      rem_in              = rem_ff;
      cnt_in              = cnt_ff;
      neg_in              = neg_ff;
      deriv_in            = deriv_ff;
      cur_pan_in          = cur_pan_ff;
      cur_tilt_in         = cur_tilt_ff;
      last_pan_in         = last_pan_ff;
      last_tilt_in        = last_tilt_ff;
      integ_pan_in        = integ_pan_ff;
      integ_tilt_in       = integ_tilt_ff;
      pan_cmd_in          = pan_cmd_ff;
      tilt_cmd_in         = tilt_cmd_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_pan_command_in  = rsp_pan_command_ff;
      rsp_tilt_command_in = rsp_tilt_command_ff;

      case (state_ff)
         // take in one command beat
         S_IDLE: begin
            if (req_fire) begin
               act_in   = action_type'(req_action);
               ticks_in = req_position_ticks;
               pv_in    = req_pan_value;
               tv_in    = req_tilt_value;
               seen_in  = req_object_seen;
               dt_in    = (req_elapsed_us == '0) ? DtW'(1) : req_elapsed_us;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            axis_in = 1'b0;
            case (act_ff)
               ACT_TILT_REPORT, ACT_PAN_REPORT: state_in = S_TICK_MUL;
               ACT_ABS_MOVE: begin
                  pan_cmd_in  = pv_ff;
                  tilt_cmd_in = tv_ff;
                  state_in    = S_EMIT;
               end
               ACT_REL_MOVE: state_in = S_LEAK_MUL;
               ACT_TRACKER:  state_in = seen_ff ? S_LEAK_MUL : S_IDLE;
               default:      state_in = S_IDLE;
            endcase
         end
         // servo report to angle
         S_TICK_MUL: state_in = S_TICK_WB;
         S_TICK_WB: begin
            if (act_ff == ACT_PAN_REPORT) begin
               cur_pan_in = sat_angle(SatW'(tick_round));
            end else begin
               cur_tilt_in = sat_angle(SatW'(tick_round));
            end
            state_in = S_IDLE;
         end
         // leaky integral
         S_LEAK_MUL: state_in = S_INTEG_WB;
         S_INTEG_WB: begin
            if (axis_ff) begin
               integ_pan_in = integ_new;
            end else begin
               integ_tilt_in = integ_new;
            end
            state_in = S_NUM_MUL;
         end
         // error change scaled to microseconds
         S_NUM_MUL: begin
            neg_in   = err_diff[AngleW];
            state_in = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            numq_in = {prod_ff[QuotW-UsScaleShift-1:0], {UsScaleShift{1'b0}}};
            rem_in  = '0;
            cnt_in  = DivCntW'(QuotW - 1);
            if (axis_ff) begin
               last_pan_in = err_sel;
            end else begin
               last_tilt_in = err_sel;
            end
            state_in = S_DIV;
         end
         // restoring divide by elapsed time, one quotient bit a cycle
         S_DIV: begin
            rem_in  = div_bit ? DtW'(div_trial - {1'b0, dt_ff}) : div_trial[DtW-1:0];
            numq_in = {numq_ff[QuotW-2:0], div_bit};
            cnt_in  = cnt_ff - DivCntW'(1);
            if (cnt_ff == '0) begin
               state_in = S_DERIV;
            end
         end
         S_DERIV: begin
            deriv_in = neg_ff ? -$signed({1'b0, numq_ff}) : $signed({1'b0, numq_ff});
            state_in = S_KP;
         end
         // multiply-accumulate of the three terms
         S_KP:  state_in = S_KI;
         S_KI: begin
            acc_in   = AccW'(prod_ff);
            state_in = S_KDL;
         end
         S_KDL: begin
            acc_in   = acc_ff + AccW'(prod_ff);
            state_in = S_KDH;
         end
         S_KDH: begin
            acc_in   = acc_ff + AccW'(prod_ff);
            state_in = S_ACC_LAST;
         end
         S_ACC_LAST: begin
            acc_in   = acc_ff + (AccW'(prod_ff) <<< DerivLoW);
            state_in = S_OUT;
         end
         // command for this axis, then the other axis or the result
         S_OUT: begin
            if (axis_ff) begin
               pan_cmd_in = cmd_new;
               state_in   = S_EMIT;
            end else begin
               tilt_cmd_in = cmd_new;
               axis_in     = 1'b1;
               state_in    = S_LEAK_MUL;
            end
         end
         // hand the result to the output register once it is free
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_pan_command_in  = pan_cmd_ff;
               rsp_tilt_command_in = tilt_cmd_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         axis_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cur_pan_ff    <= '0;
         cur_tilt_ff   <= '0;
         last_pan_ff   <= '0;
         last_tilt_ff  <= '0;
         integ_pan_ff  <= '0;
         integ_tilt_ff <= '0;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_pan_ff    <= cur_pan_in;
         cur_tilt_ff   <= cur_tilt_in;
         last_pan_ff   <= last_pan_in;
         last_tilt_ff  <= last_tilt_in;
         integ_pan_ff  <= integ_pan_in;
         integ_tilt_ff <= integ_tilt_in;
      end
      act_ff              <= act_in;
      ticks_ff            <= ticks_in;
      pv_ff               <= pv_in;
      tv_ff               <= tv_in;
      seen_ff             <= seen_in;
      dt_ff               <= dt_in;
      prod_ff             <= prod_in;
      acc_ff              <= acc_in;
      numq_ff             <= numq_in;
      rem_ff              <= rem_in;
      cnt_ff              <= cnt_in;
      neg_ff              <= neg_in;
      deriv_ff            <= deriv_in;
      pan_cmd_ff          <= pan_cmd_in;
      tilt_cmd_ff         <= tilt_cmd_in;
      rsp_pan_command_ff  <= rsp_pan_command_in;
      rsp_tilt_command_ff <= rsp_tilt_command_in;
   end

`ifndef SYNTHESIS
   // one command in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in flight");

   // a waiting result does not overwrite the one still held at the output
   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && rsp_valid_ff && !rsp_ready
      |=> state_ff == S_EMIT && $stable(rsp_pan_command_ff)
          && $stable(rsp_tilt_command_ff))
      else $error("held result overwritten under stall");

   // a servo report finishes without producing a result
   a_report_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK_WB |=> state_ff == S_IDLE && !$rose(rsp_valid_ff))
      else $error("servo report produced a result");
`endif

endmodule
